>>> src/abas_pkg.sv
`default_nettype none
package abas_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN_LOG2 = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDR  = 8'd3;

  localparam logic [31:0] CAPACITY_RESET = 32'd65536;
  localparam logic [2:0]  ALIGN_RESET    = 3'd3;
  localparam logic [31:0] REC_MAX        = 32'hFFFF_FFFF;

  localparam logic [1:0] REQ_ALLOC     = 2'd0;
  localparam logic [1:0] REQ_REL_BYTES = 2'd1;
  localparam logic [1:0] REQ_REL_ADDR  = 2'd2;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_ZERO_SIZE = 3'd1;
  localparam logic [2:0] STS_NO_SPACE  = 3'd2;
  localparam logic [2:0] STS_EXCEEDS   = 3'd3;
  localparam logic [2:0] STS_FULL      = 3'd4;
  localparam logic [2:0] STS_NOT_TOP   = 3'd5;
  localparam logic [2:0] STS_EMPTY     = 3'd6;
  localparam logic [2:0] STS_UNDERFLOW = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] amount;
    logic [63:0] block_addr;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] alloc_addr;
    logic [31:0] fill_level;
  } out_word_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] capacity;
    logic [2:0]  align_log2;
    logic [63:0] base_addr;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_END,
    ST_ALIGN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> src/aligned_bump_allocator_with_size_stack.sv
`default_nettype none
// Arena bump allocator with a stack of allocation sizes held in a single-port-write RAM.
// Each request passes through these steps from acceptance to its result word: the stack
// RAM read of the top record happens at the accepting edge, then check, end sum, alignment
// and commit stages follow, with the commit writing the RAM and the level. A new request is
// accepted in the cycle after the commit; a result waits in an output register while the
// result side stalls, and the input is taken again meanwhile.
// Configuration writes are accepted every cycle and must only be issued while idle.
module aligned_bump_allocator_with_size_stack
  import abas_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int LEVEL_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_word_t               in_word,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_word_t                   out_word
);

  cfg_t cfg;

  abas_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  abas_engine #(
    .STACK_DEPTH(STACK_DEPTH),
    .LEVEL_WIDTH(LEVEL_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

>>> src/abas_ram.sv
`default_nettype none
module abas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/abas_cfg_regs.sv
`default_nettype none
module abas_cfg_regs
  import abas_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:       cfg_nxt.mode       = cfg_data[0];
        CFG_CAPACITY:   cfg_nxt.capacity   = cfg_data[31:0];
        CFG_ALIGN_LOG2: cfg_nxt.align_log2 = cfg_data[2:0];
        CFG_BASE_ADDR:  cfg_nxt.base_addr  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= 1'b0;
      cfg_r.capacity   <= CAPACITY_RESET;
      cfg_r.align_log2 <= ALIGN_RESET;
      cfg_r.base_addr  <= 64'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/abas_engine.sv
`default_nettype none
module abas_engine
  import abas_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int LEVEL_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = ((LEVEL_WIDTH > 32) ? LEVEL_WIDTH : 32) + 2;
  localparam logic [CW-1:0]          DEPTH_C   = CW'(STACK_DEPTH);
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;

  state_t state_r, state_nxt;

  logic [LEVEL_WIDTH-1:0] used_r, used_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  in_word_t               req_r;
  logic                   out_valid_r;
  out_word_t              out_word_r;

  logic zero_r, full_r, over_r, cap_ex_r, empty_r, top_gt_r, under_r, match_r;
  logic zero_nxt, full_nxt, over_nxt, cap_ex_nxt, empty_nxt, top_gt_nxt, under_nxt;
  logic match_nxt;
  logic [LEVEL_WIDTH-1:0] diff_r, rel_r, start_r, end_sat_r;
  logic [LEVEL_WIDTH-1:0] diff_nxt, rel_nxt, start_nxt, end_sat_nxt;
  logic [SW-1:0]          end_r, end_nxt;
  logic [63:0]            addr_r, addr_nxt;

  logic [31:0]   top_rdata;
  logic [SW-1:0] used_ext, amt_ext, cap_ext, top_ext, mask_s, end_al, rec_full;
  logic [31:0]   rec;
  logic          done_go;
  logic          ram_we;
  logic [2:0]    sts;
  logic [63:0]   res_addr;

  abas_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(rec),
    .raddr(AW'(count_r - CW'(1))),
    .rdata(top_rdata)
  );

  assign used_ext = SW'(used_r);
  assign amt_ext  = SW'(req_r.amount);
  assign cap_ext  = SW'(cfg.capacity);
  assign top_ext  = SW'(top_rdata);

  always_comb begin
    zero_nxt   = (req_r.amount == 32'd0);
    full_nxt   = (count_r == DEPTH_C);
    over_nxt   = ((used_ext + amt_ext) > cap_ext);
    cap_ex_nxt = (req_r.amount > cfg.capacity);
    empty_nxt  = (count_r == CW'(0));
    top_gt_nxt = (top_ext > used_ext);
    under_nxt  = (amt_ext > used_ext);
    diff_nxt   = LEVEL_WIDTH'(used_ext - top_ext);
    rel_nxt    = LEVEL_WIDTH'(used_ext - amt_ext);
    start_nxt  = (over_nxt && cfg.mode) ? '0 : used_r;
  end

  always_comb begin
    end_nxt   = SW'(start_r) + amt_ext;
    match_nxt = ((cfg.base_addr + 64'(diff_r)) == req_r.block_addr);
  end

  always_comb begin
    mask_s      = (SW'(1) << cfg.align_log2) - SW'(1);
    end_al      = (end_r + mask_s) & ~mask_s;
    end_sat_nxt = (end_al[SW-1:LEVEL_WIDTH] != '0) ? LEVEL_MAX : end_al[LEVEL_WIDTH-1:0];
    addr_nxt    = cfg.base_addr + 64'(start_r);
  end

  always_comb begin
    rec_full = SW'(end_sat_r) - SW'(start_r);
    rec      = (rec_full > SW'(REC_MAX)) ? REC_MAX : rec_full[31:0];
  end

  assign done_go = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    sts       = STS_OK;
    res_addr  = 64'd0;
    used_nxt  = used_r;
    count_nxt = count_r;
    ram_we    = 1'b0;
    case (req_r.req_type)
      REQ_ALLOC: begin
        if (zero_r) begin
          sts = STS_ZERO_SIZE;
        end else if (full_r) begin
          sts = STS_FULL;
        end else if (over_r && !cfg.mode) begin
          sts = STS_NO_SPACE;
        end else if (over_r && cap_ex_r) begin
          sts = STS_EXCEEDS;
          if (done_go) used_nxt = '0;
        end else begin
          res_addr = addr_r;
          if (done_go) begin
            used_nxt  = end_sat_r;
            count_nxt = count_r + CW'(1);
            ram_we    = 1'b1;
          end
        end
      end
      REQ_REL_BYTES: begin
        if (under_r) begin
          sts = STS_UNDERFLOW;
          if (done_go) used_nxt = '0;
        end else if (done_go) begin
          used_nxt = rel_r;
        end
      end
      REQ_REL_ADDR: begin
        if (empty_r) begin
          sts = STS_EMPTY;
        end else if (top_gt_r || !match_r) begin
          sts = STS_NOT_TOP;
        end else if (done_go) begin
          used_nxt  = diff_r;
          count_nxt = count_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: state_nxt = ST_END;
      ST_END:   state_nxt = ST_ALIGN;
      ST_ALIGN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (done_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      count_r <= count_nxt;
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_word;
    end
    if (state_r == ST_CHECK) begin
      zero_r   <= zero_nxt;
      full_r   <= full_nxt;
      over_r   <= over_nxt;
      cap_ex_r <= cap_ex_nxt;
      empty_r  <= empty_nxt;
      top_gt_r <= top_gt_nxt;
      under_r  <= under_nxt;
      diff_r   <= diff_nxt;
      rel_r    <= rel_nxt;
      start_r  <= start_nxt;
    end
    if (state_r == ST_END) begin
      end_r   <= end_nxt;
      match_r <= match_nxt;
    end
    if (state_r == ST_ALIGN) begin
      end_sat_r <= end_sat_nxt;
      addr_r    <= addr_nxt;
    end
    if (done_go) begin
      out_word_r.status     <= sts;
      out_word_r.alloc_addr <= res_addr;
      out_word_r.fill_level <= 32'(used_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

>>> src/abas_checker.sv
`default_nettype none
module abas_checker
  import abas_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("Result word dropped or changed while stalled.");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != STS_OK) |-> out_word.alloc_addr == 64'd0)
    else $error("Refused request returned a non-zero address.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Second word accepted while a request is in progress.");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("Result appeared in the cycle after acceptance.");

endmodule

bind aligned_bump_allocator_with_size_stack abas_checker u_abas_checker (.*);
`default_nettype wire

>>> sim/aligned_bump_allocator_with_size_stack_tb.sv
`timescale 1ns / 1ps
module aligned_bump_allocator_with_size_stack_tb;
  import abas_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int IDLE_LIMIT = 2000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;

  aligned_bump_allocator_with_size_stack uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  always #4 clk = ~clk;

  logic arena_mode;
  logic [31:0] arena_capacity;
  logic [2:0] arena_align;
  logic [63:0] arena_base;
  logic [31:0] arena_level;
  logic [31:0] rec_sizes [STACK_DEPTH];
  int unsigned stack_used;

  out_word_t pending_results [$];
  out_word_t result_want;
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit no_stalls = 1'b0;
  int unsigned ready_hold = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_stalls) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Works out the result word of one request and advances the arena state.
  function automatic out_word_t allocator_response(in_word_t w);
    out_word_t r;
    logic [31:0] start;
    logic [31:0] top;
    logic [63:0] fin;
    logic [63:0] mask;
    bit fits;
    r = '0;
    r.status = STS_OK;
    case (w.req_type)
      REQ_ALLOC: begin
        if (w.amount == 0) begin
          r.status = STS_ZERO_SIZE;
        end else if (stack_used >= STACK_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          fits = 1'b1;
          if ({1'b0, arena_level} + {1'b0, w.amount} > {1'b0, arena_capacity}) begin
            if (!arena_mode) begin
              r.status = STS_NO_SPACE;
              fits = 1'b0;
            end else begin
              arena_level = '0;
              if (w.amount > arena_capacity) begin
                r.status = STS_EXCEEDS;
                fits = 1'b0;
              end
            end
          end
          if (fits) begin
            start = arena_level;
            fin = 64'(start) + 64'(w.amount);
            mask = (64'd1 << arena_align) - 64'd1;
            if ((fin & mask) != 0) fin = fin + (mask + 64'd1) - (fin & mask);
            if (fin > 64'hFFFF_FFFF) fin = 64'hFFFF_FFFF;
            rec_sizes[SAW'(stack_used)] = fin[31:0] - start;
            stack_used++;
            arena_level = fin[31:0];
            r.alloc_addr = arena_base + 64'(start);
          end
        end
      end
      REQ_REL_BYTES: begin
        if (w.amount > arena_level) begin
          arena_level = '0;
          r.status = STS_UNDERFLOW;
        end else begin
          arena_level = arena_level - w.amount;
        end
      end
      REQ_REL_ADDR: begin
        if (stack_used == 0) begin
          r.status = STS_EMPTY;
        end else begin
          top = rec_sizes[SAW'(stack_used - 1)];
          if (top > arena_level) begin
            r.status = STS_NOT_TOP;
          end else if (arena_base + 64'(arena_level - top) != w.block_addr) begin
            r.status = STS_NOT_TOP;
          end else begin
            arena_level = arena_level - top;
            stack_used--;
          end
        end
      end
      default: begin
      end
    endcase
    r.fill_level = arena_level;
    return r;
  endfunction

  function automatic in_word_t make_req(logic [1:0] kind, logic [31:0] amount,
                                        logic [63:0] addr);
    in_word_t w;
    w.req_type = kind;
    w.amount = amount;
    w.block_addr = addr;
    return w;
  endfunction

  function automatic logic [63:0] top_block_addr();
    if (stack_used == 0) return '0;
    return arena_base + 64'(arena_level - rec_sizes[SAW'(stack_used - 1)]);
  endfunction

  // Mostly well-formed traffic: allocations, pops of the top block and byte releases.
  function automatic in_word_t next_request();
    in_word_t w;
    int unsigned pick;
    int unsigned lim;
    w.req_type = REQ_UNUSED;
    w.amount = $urandom;
    w.block_addr = {$urandom, $urandom};
    lim = arena_capacity >> 5;
    if (lim == 0) lim = 1;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.req_type = REQ_ALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 4) w.amount = '0;
      else if (pick < 10) w.amount = $urandom;
      else if (pick < 40) w.amount = $urandom_range(1, 16);
      else w.amount = $urandom_range(1, lim);
    end else if (pick < 75) begin
      w.req_type = REQ_REL_ADDR;
      pick = $urandom_range(0, 99);
      if (stack_used != 0 && pick < 85) begin
        w.block_addr = top_block_addr();
        if (pick >= 78) w.block_addr = w.block_addr ^ (64'd1 << $urandom_range(0, 63));
      end
    end else if (pick < 95) begin
      w.req_type = REQ_REL_BYTES;
      pick = $urandom_range(0, 99);
      if (arena_level != 0 && pick < 85) w.amount = $urandom_range(0, arena_level);
    end
    return w;
  endfunction

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request outstanding: %h", out_word);
        mismatch_count++;
      end else begin
        result_want = pending_results.pop_front();
        if (out_word.status !== result_want.status) begin
          $error("status: expected %0d, got %0d", result_want.status, out_word.status);
          mismatch_count++;
        end
        if (out_word.alloc_addr !== result_want.alloc_addr) begin
          $error("alloc_addr: expected %h, got %h", result_want.alloc_addr,
                 out_word.alloc_addr);
          mismatch_count++;
        end
        if (out_word.fill_level !== result_want.fill_level) begin
          $error("fill_level: expected %h, got %h", result_want.fill_level,
                 out_word.fill_level);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic issue_request(in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(allocator_response(w));
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MODE: arena_mode = data[0];
      CFG_CAPACITY: arena_capacity = data[31:0];
      CFG_ALIGN_LOG2: arena_align = data[2:0];
      CFG_BASE_ADDR: arena_base = data;
      default: begin
      end
    endcase
  endtask

  // The block must be idle before its registers are rewritten.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(logic mode, logic [31:0] capacity, logic [2:0] align,
                           logic [63:0] base);
    wait_until_idle();
    write_reg(CFG_MODE, 64'(mode));
    write_reg(CFG_CAPACITY, 64'(capacity));
    write_reg(CFG_ALIGN_LOG2, 64'(align));
    write_reg(CFG_BASE_ADDR, base);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_basic_requests();
    issue_request(make_req(REQ_ALLOC, 32'd0, 64'd0));
    issue_request(make_req(REQ_ALLOC, 32'd1, 64'd0));
    issue_request(make_req(REQ_ALLOC, 32'd13, '1));
    issue_request(make_req(REQ_REL_ADDR, 32'd0, 64'd9));
    issue_request(make_req(REQ_REL_ADDR, 32'd0, 64'd8));
    issue_request(make_req(REQ_REL_ADDR, 32'd0, 64'd0));
    issue_request(make_req(REQ_REL_ADDR, '1, 64'd0));
    issue_request(make_req(REQ_UNUSED, '1, '1));
    issue_request(make_req(REQ_REL_BYTES, 32'd5, 64'd0));
    issue_request(make_req(REQ_ALLOC, 32'd65537, 64'd0));
    issue_request(make_req(REQ_ALLOC, '1, '1));
    issue_request(make_req(REQ_ALLOC, 32'd65536, 64'd0));
    issue_request(make_req(REQ_REL_BYTES, '1, 64'd0));
    issue_request(make_req(REQ_ALLOC, 32'd100, 64'd0));
    issue_request(make_req(REQ_REL_BYTES, 32'd4, 64'd0));
    issue_request(make_req(REQ_REL_ADDR, 32'd0, 64'd0));
  endtask

  task automatic test_stack_fill();
    configure(1'b0, CAPACITY_RESET, 3'd0, {$urandom, $urandom});
    repeat (STACK_DEPTH + 2) issue_request(make_req(REQ_ALLOC, $urandom_range(1, 200),
                                                    {$urandom, $urandom}));
    repeat (STACK_DEPTH + 1) issue_request(make_req(REQ_REL_ADDR, $urandom,
                                                    top_block_addr()));
  endtask

  task automatic test_wrap_and_alignment();
    configure(1'b1, 32'd100, 3'd6, '1);
    issue_request(make_req(REQ_ALLOC, 32'd50, 64'd0));
    issue_request(make_req(REQ_ALLOC, 32'd36, 64'd0));
    issue_request(make_req(REQ_ALLOC, 32'd1, 64'd0));
    issue_request(make_req(REQ_ALLOC, 32'd101, 64'd0));
    issue_request(make_req(REQ_REL_ADDR, 32'd0, '1));
    configure(1'b0, '1, 3'd6, 64'd0);
    issue_request(make_req(REQ_ALLOC, 32'hFFFF_FFF0, 64'd0));
    issue_request(make_req(REQ_ALLOC, 32'd1, 64'd0));
    issue_request(make_req(REQ_REL_ADDR, 32'd0, 64'd0));
    configure(1'b0, 32'd1000, 3'd0, 64'h8000_0000_0000_0000);
    issue_request(make_req(REQ_ALLOC, 32'd3, 64'd0));
    configure(1'b0, 32'd1000, 3'd7, 64'h8000_0000_0000_0000);
    issue_request(make_req(REQ_ALLOC, 32'd1, 64'd0));
  endtask

  task automatic run_traffic(int n, logic mode, logic [31:0] capacity, logic [2:0] align,
                             logic [63:0] base, bit quiet);
    configure(mode, capacity, align, base);
    no_stalls = quiet;
    repeat (n) issue_request(next_request());
    no_stalls = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_traffic(220, 1'b0, CAPACITY_RESET, ALIGN_RESET, 64'd0, 1'b0);
    run_traffic(200, 1'b1, 32'd4096, 3'd2, {$urandom, $urandom}, 1'b1);
    run_traffic(200, 1'b0, '1, 3'd6, {$urandom, $urandom}, 1'b0);
    run_traffic(150, 1'b1, 32'd1, 3'd0, '1, 1'b0);
    run_traffic(200, 1'b1, 32'd300, 3'd4, {$urandom, $urandom}, 1'b0);
    run_traffic(150, 1'b0, 32'd2000, 3'd0, {$urandom, $urandom}, 1'b1);
    run_traffic(150, 1'b1, $urandom_range(1, 1 << 20), 3'($urandom_range(0, 7)),
                {$urandom, $urandom}, 1'b0);
  endtask

  initial begin
    arena_mode = 1'b0;
    arena_capacity = CAPACITY_RESET;
    arena_align = ALIGN_RESET;
    arena_base = '0;
    arena_level = '0;
    stack_used = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_requests();
    test_stack_fill();
    test_wrap_and_alignment();
    test_random_traffic();
    wait_until_idle();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
